/* src/wclp_pkg.sv */
// shared types, constants and wave table for the wave column led pattern block
`timescale 1ns / 1ps

package wclp_pkg;

    // command codes of the input word
    localparam logic [1:0] CMD_RENDER  = 2'd0;
    localparam logic [1:0] CMD_TICK    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    // fixed-point and effect constants (256 columns, 32-entry wave)
    localparam int          FRAC_BITS = 6;
    localparam logic [12:0] FREQ_INIT = 13'd32;
    localparam logic [12:0] FREQ_STEP = 13'd4;
    localparam logic [12:0] FREQ_TOP  = 13'd4096;
    localparam logic [6:0]  AMP_STEP  = 7'd2;
    localparam logic [6:0]  AMP_MAX   = 7'd64;
    localparam logic [2:0]  FORE_INIT = 3'd1;
    localparam logic [2:0]  BACK_INIT = 3'd0;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_PHASE,
        S_SPAN,
        S_WALK,
        S_FINISH
    } t_state;

    // 32-sample wave, signed -4..3
    function automatic logic signed [3:0] sine_sample(input logic [4:0] idx);
        logic signed [3:0] s;
        case (idx)
            5'd0:  s = 4'sd0;
            5'd1:  s = 4'sd0;
            5'd2:  s = 4'sd1;
            5'd3:  s = 4'sd1;
            5'd4:  s = 4'sd2;
            5'd5:  s = 4'sd2;
            5'd6:  s = 4'sd3;
            5'd7:  s = 4'sd3;
            5'd8:  s = 4'sd3;
            5'd9:  s = 4'sd3;
            5'd10: s = 4'sd3;
            5'd11: s = 4'sd2;
            5'd12: s = 4'sd2;
            5'd13: s = 4'sd1;
            5'd14: s = 4'sd1;
            5'd15: s = 4'sd0;
            5'd16: s = 4'sd0;
            5'd17: s = -4'sd1;
            5'd18: s = -4'sd2;
            5'd19: s = -4'sd2;
            5'd20: s = -4'sd3;
            5'd21: s = -4'sd3;
            5'd22: s = -4'sd4;
            5'd23: s = -4'sd4;
            5'd24: s = -4'sd4;
            5'd25: s = -4'sd4;
            5'd26: s = -4'sd4;
            5'd27: s = -4'sd3;
            5'd28: s = -4'sd3;
            5'd29: s = -4'sd2;
            5'd30: s = -4'sd2;
            5'd31: s = -4'sd1;
            default: s = 4'sd0;
        endcase
        return s;
    endfunction

endpackage

/* src/wave_column_led_pattern_top.sv */
// wave column led pattern: phase sequencer, span walk and colour output
`timescale 1ns / 1ps

// Renders one column of an 8-LED RGB sine-wave effect on a 256-column display.
// A render word (cmd 0) returns one red/green/blue word; tick (cmd 1) and
// restart (cmd 2) words update the effect state on acceptance and return
// nothing; cmd 3 is ignored. A render runs through one shared phase multiplier
// for the left, center and right columns in turn, then bounds the phase span,
// then steps through each span entry in the table-times-amplitude unit (1 to
// 32 entries), and loads the output register once it is free. o_stall stays
// high while a render is in flight; a finished word waits in the output
// register.
module wave_column_led_pattern_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_column,
    input  logic [2:0] i_rand_color,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_red_bits,
    output logic [7:0] o_green_bits,
    output logic [7:0] o_blue_bits
);

    // control state
    wclp_pkg::t_state r_state, n_state;
    logic [1:0]  r_cnt, n_cnt;
    logic        r_out_valid, n_out_valid;

    // effect state
    logic [2:0]  r_fore, n_fore;
    logic [2:0]  r_back, n_back;
    logic [12:0] r_freq, n_freq;
    logic [6:0]  r_amp, n_amp;

    // render datapath registers
    logic [7:0]        r_col, n_col;
    logic [4:0]        r_ph_l, n_ph_l;
    logic [4:0]        r_ph_c, n_ph_c;
    logic [4:0]        r_ph_r, n_ph_r;
    logic signed [7:0] r_k, n_k;
    logic signed [7:0] r_hi, n_hi;
    logic [7:0]        r_mask, n_mask;
    logic [7:0]        r_red, n_red;
    logic [7:0]        r_green, n_green;
    logic [7:0]        r_blue, n_blue;

    // phase unit
    logic [7:0]         w_sel;
    logic signed [7:0]  w_d;
    logic signed [21:0] w_pprod;
    logic signed [21:0] w_pq;
    logic signed [21:0] w_pv;
    logic [4:0]         w_ph;

    // span bounds
    logic signed [7:0] w_sc, w_slx, w_srx, w_lsum, w_rsum, w_lo, w_hi;

    // scaled sample unit
    logic signed [3:0]  w_s;
    logic signed [11:0] w_sprod;
    logic signed [11:0] w_ts;
    logic [2:0]         w_led;

    // tick helper
    logic [12:0] w_freq_bump;

    // shared phase multiplier: column offset times frequency, scaled and wrapped
    always_comb begin
        case (r_cnt)
            2'd0:    w_sel = r_col - 8'd1;
            2'd1:    w_sel = r_col;
            default: w_sel = r_col + 8'd1;
        endcase
        w_d     = $signed(w_sel ^ 8'h80);
        w_pprod = $signed({{14{w_d[7]}}, w_d}) * $signed({9'b0, r_freq});
        w_pq    = (w_pprod + (w_pprod[21] ? 22'sd3 : 22'sd0)) >>> 2;
        w_pv    = w_pq + 22'sd32;
        w_ph    = w_pv[10:6];
    end

    // span between the neighbour phases
    always_comb begin
        w_sc   = $signed({3'b0, r_ph_c});
        w_slx  = (r_ph_l > r_ph_c) ? $signed({3'b0, r_ph_l}) - 8'sd32
                                   : $signed({3'b0, r_ph_l});
        w_srx  = (r_ph_r < r_ph_c) ? $signed({3'b0, r_ph_r}) + 8'sd32
                                   : $signed({3'b0, r_ph_r});
        w_lsum = w_slx + w_sc;
        w_rsum = w_sc + w_srx;
        // halve toward zero
        w_lo   = (w_slx + 8'sd1 >= w_sc) ? w_sc
               : ((w_lsum + $signed({7'b0, w_lsum[7]})) >>> 1);
        w_hi   = (w_sc >= w_srx + 8'sd1) ? w_sc : (w_rsum >>> 1);
    end

    // table sample times amplitude, rounded and clamped to an led index
    always_comb begin
        w_s     = wclp_pkg::sine_sample(r_k[4:0]);
        w_sprod = $signed({{8{w_s[3]}}, w_s}) * $signed({5'b0, r_amp});
        w_ts    = (w_sprod + 12'sd32) >>> wclp_pkg::FRAC_BITS;
        if (w_ts < -12'sd4) begin
            w_ts = -12'sd4;
        end else if (w_ts > 12'sd3) begin
            w_ts = 12'sd3;
        end
        w_led   = w_ts[2:0] ^ 3'b100;
    end

    assign w_freq_bump = r_freq + wclp_pkg::FREQ_STEP;

    // sequencer next state and datapath updates
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_stall;
        n_fore      = r_fore;
        n_back      = r_back;
        n_freq      = r_freq;
        n_amp       = r_amp;
        n_col       = r_col;
        n_ph_l      = r_ph_l;
        n_ph_c      = r_ph_c;
        n_ph_r      = r_ph_r;
        n_k         = r_k;
        n_hi        = r_hi;
        n_mask      = r_mask;
        n_red       = r_red;
        n_green     = r_green;
        n_blue      = r_blue;
        unique case (r_state)
            wclp_pkg::S_IDLE: begin
                if (i_valid) begin
                    case (i_cmd)
                        wclp_pkg::CMD_RENDER: begin
                            n_col   = i_column;
                            n_cnt   = 2'd0;
                            n_state = wclp_pkg::S_PHASE;
                        end
                        wclp_pkg::CMD_TICK: begin
                            if (w_freq_bump >= wclp_pkg::FREQ_TOP) begin
                                n_back = r_fore;
                                n_fore = (i_rand_color == r_fore) ? r_fore + 3'd1
                                                                  : i_rand_color;
                                n_freq = wclp_pkg::FREQ_INIT;
                                n_amp  = 7'd0;
                            end else begin
                                n_freq = w_freq_bump;
                                if (r_amp < wclp_pkg::AMP_MAX) begin
                                    n_amp = r_amp + wclp_pkg::AMP_STEP;
                                end
                            end
                        end
                        wclp_pkg::CMD_RESTART: begin
                            n_fore = i_rand_color;
                            n_back = (i_rand_color == 3'd0) ? 3'd1 : 3'd0;
                            n_freq = wclp_pkg::FREQ_INIT;
                            n_amp  = 7'd0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            wclp_pkg::S_PHASE: begin
                case (r_cnt)
                    2'd0:    n_ph_l = w_ph;
                    2'd1:    n_ph_c = w_ph;
                    default: n_ph_r = w_ph;
                endcase
                if (r_cnt == 2'd2) begin
                    n_state = wclp_pkg::S_SPAN;
                end else begin
                    n_cnt = r_cnt + 2'd1;
                end
            end
            wclp_pkg::S_SPAN: begin
                n_k     = w_lo;
                n_hi    = w_hi;
                n_mask  = 8'h00;
                n_state = wclp_pkg::S_WALK;
            end
            wclp_pkg::S_WALK: begin
                n_mask = r_mask | (8'h01 << w_led);
                n_k    = r_k + 8'sd1;
                if (r_k == r_hi) begin
                    n_state = wclp_pkg::S_FINISH;
                end
            end
            wclp_pkg::S_FINISH: begin
                // wait for the output register to free up
                if (!r_out_valid || !i_stall) begin
                    n_red       = r_fore[2] ? ({8{r_back[2]}} | r_mask)
                                            : ({8{r_back[2]}} & ~r_mask);
                    n_green     = r_fore[1] ? ({8{r_back[1]}} | r_mask)
                                            : ({8{r_back[1]}} & ~r_mask);
                    n_blue      = r_fore[0] ? ({8{r_back[0]}} | r_mask)
                                            : ({8{r_back[0]}} & ~r_mask);
                    n_out_valid = 1'b1;
                    n_state     = wclp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = wclp_pkg::S_IDLE;
            end
        endcase
    end

    // control and effect state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wclp_pkg::S_IDLE;
            r_cnt       <= 2'd0;
            r_out_valid <= 1'b0;
            r_fore      <= wclp_pkg::FORE_INIT;
            r_back      <= wclp_pkg::BACK_INIT;
            r_freq      <= wclp_pkg::FREQ_INIT;
            r_amp       <= 7'd0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_fore      <= n_fore;
            r_back      <= n_back;
            r_freq      <= n_freq;
            r_amp       <= n_amp;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_col   <= n_col;
        r_ph_l  <= n_ph_l;
        r_ph_c  <= n_ph_c;
        r_ph_r  <= n_ph_r;
        r_k     <= n_k;
        r_hi    <= n_hi;
        r_mask  <= n_mask;
        r_red   <= n_red;
        r_green <= n_green;
        r_blue  <= n_blue;
    end

    // ports
    assign o_stall      = (r_state != wclp_pkg::S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_red_bits   = r_red;
    assign o_green_bits = r_green;
    assign o_blue_bits  = r_blue;

endmodule

/* tb/tb_wave_column_led_pattern_top.sv */
// self-checking testbench for the wave column led pattern block
`timescale 1ns / 1ps

module tb_wave_column_led_pattern_top;

    // cmd 3 carries no operation and must be ignored
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // effect geometry and fixed-point constants
    localparam int          NUM_COLS    = 256;
    localparam int          HALF_COLS   = 128;
    localparam int          PHASES      = 32;
    localparam int          FRAC        = 6;
    localparam int          FX_HALF     = 32;
    localparam logic [6:0]  AMP_CEIL    = 7'd64;
    localparam logic [6:0]  AMP_INC     = 7'd2;
    localparam logic [12:0] FREQ_GAIN   = 13'd4;
    localparam logic [12:0] FREQ_WRAP   = 13'd4096;
    localparam logic [12:0] FREQ_START  = 13'd32;
    localparam int          DRAIN_CYCLES = 60;
    localparam int          CYCLE_LIMIT  = 1000000;

    // 32 signed 4-bit wave samples, entry 0 in the low nibble
    localparam logic [127:0] WAVE_NIBBLES = 128'hFEEDDCCCCCDDEEF0_0112233333221100;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_leds;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [1:0] i_cmd;
    logic [7:0] i_column;
    logic [2:0] i_rand_color;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_red_bits;
    logic [7:0] o_green_bits;
    logic [7:0] o_blue_bits;

    wave_column_led_pattern_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_column     (i_column),
        .i_rand_color (i_rand_color),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_red_bits   (o_red_bits),
        .o_green_bits (o_green_bits),
        .o_blue_bits  (o_blue_bits)
    );

    // mirror of the effect state
    logic [2:0]  fore_color;
    logic [2:0]  back_color;
    logic [12:0] wave_freq;
    logic [6:0]  wave_amp;

    t_leds pending_leds[$];
    int    errors = 0;
    int    cycle_count = 0;
    bit    steady_run = 0;

    // 4 ns clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver back-pressure
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_stall <= !steady_run && ($urandom_range(99) < 35);
        end
    end

    // reduce a phase into 0..PHASES-1
    function automatic int wrap_phase(input longint v);
        longint r;
        r = v % PHASES;
        if (r < 0) r += PHASES;
        return int'(r);
    endfunction

    // wave phase of one column at the current frequency
    function automatic int column_phase(input int col);
        longint prod;
        prod = (longint'(col - HALF_COLS) * longint'(wave_freq) * PHASES) / HALF_COLS;
        return wrap_phase((prod + FX_HALF) >>> FRAC);
    endfunction

    // expected led bytes for one column
    function automatic t_leds render_column(input logic [7:0] col);
        int         c;
        int         left_ph;
        int         mid_ph;
        int         right_ph;
        int         k;
        longint     level;
        logic [7:0] lit;
        t_leds      leds;
        c        = int'(col);
        mid_ph   = column_phase(c);
        left_ph  = column_phase((c == 0) ? NUM_COLS - 1 : c - 1);
        right_ph = column_phase((c + 1) % NUM_COLS);
        // unwrap the neighbours around the center phase
        if (left_ph > mid_ph) left_ph -= PHASES;
        if (right_ph < mid_ph) right_ph += PHASES;
        // span reaches halfway to each neighbour
        left_ph  = (left_ph + 1 >= mid_ph) ? mid_ph : (left_ph + mid_ph) / 2;
        right_ph = (mid_ph >= right_ph + 1) ? mid_ph : (mid_ph + right_ph) / 2;
        lit = '0;
        for (k = left_ph; k <= right_ph; k++) begin
            level = (longint'($signed(WAVE_NIBBLES[wrap_phase(k) * 4 +: 4]))
                     * longint'(wave_amp) + FX_HALF) >>> FRAC;
            if (level < -4) level = -4;
            if (level > 3) level = 3;
            lit[int'(level) + 4] = 1'b1;
        end
        // foreground on lit leds, background elsewhere
        leds.red   = fore_color[2] ? ({8{back_color[2]}} | lit) : ({8{back_color[2]}} & ~lit);
        leds.green = fore_color[1] ? ({8{back_color[1]}} | lit) : ({8{back_color[1]}} & ~lit);
        leds.blue  = fore_color[0] ? ({8{back_color[0]}} | lit) : ({8{back_color[0]}} & ~lit);
        return leds;
    endfunction

    // frame tick: ramp amplitude and frequency, swap colours on wrap
    function automatic void advance_frame(input logic [2:0] rc);
        if (wave_amp < AMP_CEIL) wave_amp += AMP_INC;
        wave_freq += FREQ_GAIN;
        if (wave_freq >= FREQ_WRAP) begin
            back_color = fore_color;
            fore_color = (rc == back_color) ? back_color + 3'd1 : rc;
            wave_freq  = FREQ_START;
            wave_amp   = '0;
        end
    endfunction

    // restart: new foreground, black background unless they collide
    function automatic void restart_effect(input logic [2:0] rc);
        fore_color = rc;
        back_color = (rc == 3'd0) ? 3'd1 : 3'd0;
        wave_freq  = FREQ_START;
        wave_amp   = '0;
    endfunction

    // update the mirror for one accepted word
    function automatic void predict_word(input logic [1:0] cmd, input logic [7:0] col,
                                         input logic [2:0] rc);
        case (cmd)
            wclp_pkg::CMD_RENDER:  pending_leds.push_back(render_column(col));
            wclp_pkg::CMD_TICK:    advance_frame(rc);
            wclp_pkg::CMD_RESTART: restart_effect(rc);
            default: ;
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    // compare each delivered word with the oldest expectation
    always @(posedge i_clk) begin : check_leds
        t_leds want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_leds.size() == 0) begin
                $display("%0t: unexpected word, expected none actual %h %h %h",
                         $time, o_red_bits, o_green_bits, o_blue_bits);
                errors++;
            end else begin
                want = pending_leds.pop_front();
                check_field("red", want.red, o_red_bits);
                check_field("green", want.green, o_green_bits);
                check_field("blue", want.blue, o_blue_bits);
            end
        end
    end

    // drive one word, called and returning at a falling edge
    task automatic send_word(input logic [1:0] cmd, input logic [7:0] col,
                             input logic [2:0] rc);
        if (!steady_run) begin
            while ($urandom_range(99) < 35) begin
                i_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_valid      <= 1'b1;
        i_cmd        <= cmd;
        i_column     <= col;
        i_rand_color <= rc;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_word(cmd, col, rc);
        @(negedge i_clk);
    endtask

    // hold the sender off until every render has come back
    task automatic wait_results_drained();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending_leds.size() != 0);
    endtask

    // column extremes and bit patterns at the reset state
    task automatic test_columns_at_reset();
        logic [7:0] probe_cols [9];
        probe_cols = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd129, 8'd254, 8'd255, 8'h55, 8'hAA};
        foreach (probe_cols[i])
            send_word(wclp_pkg::CMD_RENDER, probe_cols[i], 3'($urandom_range(7)));
    endtask

    // every command, restart colour collision and the ignored command
    task automatic test_commands();
        send_word(CMD_UNUSED, 8'($urandom_range(255)), 3'($urandom_range(7)));
        send_word(wclp_pkg::CMD_RENDER, 8'h0F, 3'($urandom_range(7)));
        send_word(wclp_pkg::CMD_RESTART, 8'($urandom_range(255)), 3'd0);
        send_word(wclp_pkg::CMD_RENDER, 8'hF0, 3'($urandom_range(7)));
        send_word(wclp_pkg::CMD_RESTART, 8'($urandom_range(255)), 3'd7);
        send_word(wclp_pkg::CMD_RENDER, 8'd64, 3'($urandom_range(7)));
        repeat (3)
            send_word(wclp_pkg::CMD_TICK, 8'($urandom_range(255)), 3'($urandom_range(7)));
        send_word(wclp_pkg::CMD_RENDER, 8'd192, 3'($urandom_range(7)));
        send_word(wclp_pkg::CMD_RESTART, 8'($urandom_range(255)), 3'd5);
        send_word(wclp_pkg::CMD_RENDER, 8'd32, 3'($urandom_range(7)));
        wait_results_drained();
    endtask

    // two full frequency sweeps up to the wrap, renders scattered in between;
    // the first wrap picks the old foreground again, the second does not
    task automatic test_frequency_wraps();
        int         sweep;
        int         count;
        int         roll;
        bit         wrapped;
        logic [2:0] rc;
        send_word(wclp_pkg::CMD_RESTART, 8'($urandom_range(255)), 3'($urandom_range(7)));
        for (sweep = 0; sweep < 2; sweep++) begin
            wrapped    = 1'b0;
            count      = 0;
            steady_run = (sweep == 1);
            while (!wrapped) begin
                if (count == 300) steady_run = 1'b0;
                count++;
                roll = $urandom_range(99);
                if (roll < 4) begin
                    send_word(wclp_pkg::CMD_RENDER, 8'($urandom_range(255)),
                              3'($urandom_range(7)));
                end else if (roll < 5) begin
                    send_word(CMD_UNUSED, 8'($urandom_range(255)), 3'($urandom_range(7)));
                end else begin
                    rc = 3'($urandom_range(7));
                    wrapped = (wave_freq + FREQ_GAIN >= FREQ_WRAP);
                    if (wrapped)
                        rc = (sweep == 0) ? fore_color : fore_color ^ 3'($urandom_range(7, 1));
                    send_word(wclp_pkg::CMD_TICK, 8'($urandom_range(255)), rc);
                end
            end
            // renders right after the colour swap
            repeat (4)
                send_word(wclp_pkg::CMD_RENDER, 8'($urandom_range(255)),
                          3'($urandom_range(7)));
            wait_results_drained();
        end
    endtask

    // random mix of all commands
    task automatic test_random_mix();
        int roll;
        repeat (40) begin
            roll = $urandom_range(99);
            if (roll < 50)
                send_word(wclp_pkg::CMD_RENDER, 8'($urandom_range(255)),
                          3'($urandom_range(7)));
            else if (roll < 82)
                send_word(wclp_pkg::CMD_TICK, 8'($urandom_range(255)),
                          3'($urandom_range(7)));
            else if (roll < 95)
                send_word(wclp_pkg::CMD_RESTART, 8'($urandom_range(255)),
                          3'($urandom_range(7)));
            else
                send_word(CMD_UNUSED, 8'($urandom_range(255)), 3'($urandom_range(7)));
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_cmd        = wclp_pkg::CMD_RENDER;
        i_column     = '0;
        i_rand_color = '0;
        fore_color   = 3'd1;
        back_color   = 3'd0;
        wave_freq    = FREQ_START;
        wave_amp     = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_columns_at_reset();
        test_commands();
        test_frequency_wraps();
        test_random_mix();

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
